@@ hdl/rgpt_pkg.sv @@
// Shared types and constants for the recent goal proximity table.
// Used by rgpt_ctrl, rgpt_datapath and the top level; depends on nothing.
package rgpt_pkg;

  localparam int RADIUS_W    = 23;
  localparam int KEEP_W      = 4;
  localparam int ROBOT_IDX_W = 4;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 23;
  localparam int OUT_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_RADIUS = 4'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_KEEP   = 4'd1;
  localparam logic [RADIUS_W-1:0]   RADIUS_RESET   = 23'd256;
  localparam logic [KEEP_W-1:0]     KEEP_RESET     = 4'd5;

  typedef enum logic {
    FUNC_PUSH  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request and clear the scan
    logic push;       // store the captured goal
    logic scan_step;  // issue one table read
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic out_full;
  } status_t;

endpackage

@@ hdl/rgpt_ctrl.sv @@
// Controller state machine for the recent goal proximity table.
// Depends on rgpt_pkg; drives the datapath through cmd_t and reads status_t.
module rgpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_func,
  input  logic              out_tready,
  output rgpt_pkg::cmd_t    cmd,
  input  rgpt_pkg::status_t status
);
  import rgpt_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_func == FUNC_QUERY) ? ST_SCAN : ST_PUSH;
        end
      end
      ST_PUSH: begin
        state_nxt = ST_FINISH;
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_full || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_FINISH: begin
        cmd.out_load = !status.out_full || out_tready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A result may only be taken once every table read has been compared.
  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !status.pipe_busy)
    else $error("result loaded while compare pipeline still busy");

  // An accepted query starts scanning in the following cycle.
  a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_QUERY) |=> cmd.scan_step)
    else $error("query accepted without starting the scan");

endmodule

@@ hdl/rgpt_datapath.sv @@
// Datapath of the recent goal proximity table: configuration registers,
// per-robot ring counters, the goal memory, the distance pipeline and the
// output register. Depends on rgpt_pkg; controlled by rgpt_ctrl.
module rgpt_datapath #(
  parameter int ROBOTS     = 16,
  parameter int KEEP_MAX   = 8,
  parameter int COORD_BITS = 24,
  parameter int IN_DATA_W  = 80
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rgpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgpt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]            in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [rgpt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  input  rgpt_pkg::cmd_t                  cmd,
  output rgpt_pkg::status_t               status
);
  import rgpt_pkg::*;

  localparam int SLOT_W  = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
  localparam int ROBOT_W = (ROBOTS > 1) ? $clog2(ROBOTS) : 1;
  localparam int ADDR_W  = ROBOT_W + SLOT_W;
  localparam int DEPTH   = ROBOTS * (2 ** SLOT_W);
  localparam int CNT_W   = $clog2(KEEP_MAX + 1);
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int CMP_W   = (DIFF_W > RADIUS_W) ? DIFF_W : RADIUS_W;
  localparam int SQ_W    = 2 * RADIUS_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int MEM_W   = 3 * COORD_BITS;

  // Configuration registers.
  logic [RADIUS_W-1:0] radius_r;
  logic [KEEP_W-1:0]   keep_r;
  logic [SQ_W-1:0]     rsq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
      keep_r   <= KEEP_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_RADIUS) begin
        radius_r <= cfg_data[RADIUS_W-1:0];
      end else if (cfg_index == CFG_IDX_KEEP) begin
        keep_r <= cfg_data[KEEP_W-1:0];
      end
    end
  end

  // Squared radius is registered from the radius register, well before a
  // query reaches the final compare.
  always_ff @(posedge clk) begin
    rsq_r <= SQ_W'(radius_r) * SQ_W'(radius_r);
  end

  // Captured request.
  func_t                  item_func_r;
  logic [ROBOT_IDX_W-1:0] item_robot_r;
  logic [COORD_BITS-1:0]  item_pos_r [3];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func_r  <= func_t'(in_tuser);
      item_robot_r <= in_tdata[ROBOT_IDX_W-1:0];
      for (int a = 0; a < 3; a++) begin
        item_pos_r[a] <= in_tdata[ROBOT_IDX_W + a*COORD_BITS +: COORD_BITS];
      end
    end
  end

  // Ring bookkeeping per robot.
  logic [CNT_W-1:0]   cnt_r  [ROBOTS];
  logic [SLOT_W-1:0]  slot_r [ROBOTS];
  logic [CNT_W-1:0]   ring_n;
  logic               push_ok;
  logic [ROBOT_W-1:0] push_robot;
  logic [ROBOT_W-1:0] scan_robot;
  logic [SLOT_W-1:0]  scan_slot;
  logic [ROBOT_W-1:0] sel_robot;
  logic [CNT_W-1:0]   cnt_sel;
  logic [SLOT_W-1:0]  slot_sel;
  logic [SLOT_W-1:0]  slot_eff;
  logic [SLOT_W-1:0]  slot_nxt;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [ADDR_W-1:0]  scan_addr_r;

  assign push_ok    = (32'(item_robot_r) < ROBOTS);
  assign push_robot = ROBOT_W'(item_robot_r);
  assign scan_robot = scan_addr_r[ADDR_W-1:SLOT_W];
  assign scan_slot  = scan_addr_r[SLOT_W-1:0];
  assign sel_robot  = cmd.push ? push_robot : scan_robot;
  assign cnt_sel    = cnt_r[sel_robot];
  assign slot_sel   = slot_r[sel_robot];

  always_comb begin
    if (keep_r == '0) begin
      ring_n = CNT_W'(1);
    end else if (32'(keep_r) > KEEP_MAX) begin
      ring_n = CNT_W'(KEEP_MAX);
    end else begin
      ring_n = CNT_W'(keep_r);
    end
  end

  // A slot left beyond a lowered ring size wraps to the start first.
  always_comb begin
    slot_eff = (32'(slot_sel) >= 32'(ring_n)) ? '0 : slot_sel;
    slot_nxt = (32'(slot_eff) + 1 >= 32'(ring_n)) ? '0 : SLOT_W'(32'(slot_eff) + 1);
    cnt_nxt  = (cnt_sel < ring_n) ? CNT_W'(cnt_sel + 1'b1) : ring_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROBOTS; i++) begin
        cnt_r[i]  <= '0;
        slot_r[i] <= '0;
      end
    end else if (cmd.push && push_ok) begin
      cnt_r[push_robot]  <= cnt_nxt;
      slot_r[push_robot] <= slot_nxt;
    end
  end

  // Goal memory, one write port and one registered read port.
  logic [MEM_W-1:0] goal_mem [DEPTH];
  logic [MEM_W-1:0] rd_data_r;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_wa;

  assign mem_we = cmd.push && push_ok;
  assign mem_wa = {push_robot, slot_eff};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      goal_mem[mem_wa] <= {item_pos_r[2], item_pos_r[1], item_pos_r[0]};
    end
    rd_data_r <= goal_mem[scan_addr_r];
  end

  // Scan address counter.
  logic issue_v;

  assign issue_v = cmd.scan_step && (32'(scan_slot) < 32'(cnt_sel));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
    end else if (cmd.load) begin
      scan_addr_r <= '0;
    end else if (cmd.scan_step) begin
      scan_addr_r <= scan_addr_r + 1'b1;
    end
  end

  // Stage 2: per-axis absolute difference and bound check.
  logic                v1_r, v2_r, v3_r;
  logic [DIFF_W-1:0]   dabs [3];
  logic [2:0]          axis_near;
  logic [RADIUS_W-1:0] d_r  [3];
  logic [SQ_W-1:0]     sq_r [3];
  logic                hit_r;

  always_comb begin
    logic [COORD_BITS-1:0]   g;
    logic [COORD_BITS-1:0]   p;
    logic signed [DIFF_W-1:0] diff;
    for (int a = 0; a < 3; a++) begin
      g       = rd_data_r[a*COORD_BITS +: COORD_BITS];
      p       = item_pos_r[a];
      diff    = $signed({g[COORD_BITS-1], g}) - $signed({p[COORD_BITS-1], p});
      dabs[a] = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      axis_near[a] = CMP_W'(dabs[a]) < CMP_W'(radius_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue_v;
      v2_r <= v1_r && (&axis_near);
      v3_r <= v2_r;
    end
  end

  // Each difference is below the radius once it passes the bound check,
  // so it fits the radius width.
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      d_r[a]  <= RADIUS_W'(dabs[a]);
      sq_r[a] <= SQ_W'(d_r[a]) * SQ_W'(d_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r <= 1'b0;
    end else if (v3_r && (SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2])
                          < SUM_W'(rsq_r))) begin
      hit_r <= 1'b1;
    end
  end

  // Output register.
  logic  out_valid_r;
  func_t out_func_r;
  logic  out_coll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_func_r <= item_func_r;
      out_coll_r <= (item_func_r == FUNC_QUERY) && hit_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_func_r;
  assign out_tdata  = OUT_DATA_W'(out_coll_r);

  assign status.scan_last = (scan_addr_r == ADDR_W'(DEPTH - 1));
  assign status.pipe_busy = v1_r || v2_r || v3_r;
  assign status.out_full  = out_valid_r;

  a_push_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_coll_r && out_func_r == FUNC_PUSH))
    else $error("push reported a collision");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && push_ok) |=> (cnt_r[push_robot] != '0))
    else $error("goal count empty after a push");

  a_hit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(hit_r) |-> $past(v3_r))
    else $error("hit set without a compared entry");

endmodule

@@ hdl/recent_goal_proximity_table.sv @@
// Top level of the recent goal proximity table.
// Depends on rgpt_pkg, rgpt_ctrl and rgpt_datapath.
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid/in_tready    tuser func, tdata robot and position
//   out_     master     out_tvalid/out_tready  tuser done_func, tdata collision
//   cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A push request passes from acceptance through the push and finish states.
// A query scans the whole goal memory, ROBOTS * 2**ceil(log2(KEEP_MAX))
// entries (128 at the defaults), at one read per cycle; the drain of
// the compare pipeline after the last read is shorter when no entry is in it.
// Reset clears goal counts and write slots at once; no clearing pass runs.
// The output register holds one result; the next request is accepted while
// it waits, and that request's result waits until the register is free.
module recent_goal_proximity_table #(
  parameter int ROBOTS     = 16,
  parameter int KEEP_MAX   = 8,
  parameter int COORD_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // tdata: robot_index[3:0], pos_x, pos_y, pos_z, zero fill
  input  logic [((rgpt_pkg::ROBOT_IDX_W + 3*COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // tuser: func
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // tdata: collision, zero fill
  output logic [rgpt_pkg::OUT_DATA_W-1:0]        out_tdata,
  // tuser: done_func
  output logic                                   out_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rgpt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rgpt_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import rgpt_pkg::*;

  localparam int IN_DATA_W = ((ROBOT_IDX_W + 3*COORD_BITS + 7) / 8) * 8;

  cmd_t    cmd;
  status_t status;

  rgpt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  rgpt_datapath #(
    .ROBOTS     (ROBOTS),
    .KEEP_MAX   (KEEP_MAX),
    .COORD_BITS (COORD_BITS),
    .IN_DATA_W  (IN_DATA_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
